>>> hdl/kle_pkg.sv
// shared constants, key codes and controller/datapath interface types for the line editor
package kle_pkg;

    // line buffer geometry
    localparam int LINE_CAP = 128;
    localparam int PTR_W    = $clog2(LINE_CAP);
    localparam int CNT_W    = $clog2(LINE_CAP + 1);
    localparam int WIDE_W   = (CNT_W > 8) ? CNT_W : 8;

    // field widths
    localparam int KEY_W  = 16;
    localparam int CODE_W = 9;
    localparam int RPOS_W = 7;
    localparam int CHAR_W = 8;
    localparam int MAXL_W = 8;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // configuration register index and reset value
    localparam logic             CFG_IDX_MAX_LEN = 1'b0;
    localparam logic [MAXL_W-1:0] MAX_LEN_RST    = 8'd80;

    // key codes, extended keys carry bit 8
    localparam logic [CODE_W-1:0] KEY_ENTER    = 9'd13;
    localparam logic [CODE_W-1:0] KEY_ESC      = 9'd27;
    localparam logic [CODE_W-1:0] KEY_BKSP     = 9'd8;
    localparam logic [CODE_W-1:0] KEY_LEFT     = 9'd331;
    localparam logic [CODE_W-1:0] KEY_RIGHT    = 9'd333;
    localparam logic [CODE_W-1:0] KEY_INS      = 9'd338;
    localparam logic [CODE_W-1:0] KEY_DEL      = 9'd339;
    localparam logic [CODE_W-1:0] KEY_END      = 9'd335;
    localparam logic [CODE_W-1:0] KEY_HOME     = 9'd327;
    localparam logic [CODE_W-1:0] KEY_CTRL_END = 9'd373;
    localparam logic [CODE_W-1:0] PRINT_LO     = 9'd32;
    localparam logic [CODE_W-1:0] PRINT_HI     = 9'd127;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic shift_init;
        logic rd;
        logic wr;
        logic put;
        logic close;
        logic apply;
        logic out_load;
    } kle_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_read;
        logic is_print;
        logic need_open;
        logic need_close;
        logic more;
        logic shift_up;
        logic out_free;
    } kle_sts_t;

endpackage

>>> hdl/kle_ram.sv
// generic simple dual-port ram with registered read
module kle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/kle_ctrl.sv
// sequencing state machine of the line editor
module kle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  kle_pkg::kle_sts_t sts,
    output kle_pkg::kle_cmd_t cmd
);
    import kle_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_SH_RD  = 7'b0000100,
        S_SH_WR  = 7'b0001000,
        S_PUT    = 7'b0010000,
        S_CLOSE  = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // new requests only in idle
    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_read)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_FINISH;
                end
                else if (sts.need_open || sts.need_close)
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SH_RD;
                end
                else if (sts.is_print)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_SH_RD:
            begin
                if (sts.more)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_SH_WR;
                end
                else if (sts.shift_up)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_CLOSE;
                end
            end
            S_SH_WR:
            begin
                cmd.wr     = 1'b1;
                state_next = S_SH_RD;
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_FINISH;
            end
            S_CLOSE:
            begin
                cmd.close  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DECODE))
        else $error("accepted request did not reach decode");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_WR) |-> $past(state_reg == S_SH_RD))
        else $error("shift write without preceding read");
`endif

endmodule

>>> hdl/kle_dp.sv
// line editor datapath: line ram, length, cursor, insert flag, limit and result register
module kle_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kle_pkg::kle_cmd_t             cmd,
    output kle_pkg::kle_sts_t             sts,
    input  logic                          func,
    input  logic [kle_pkg::KEY_W-1:0]     key_word,
    input  logic [kle_pkg::RPOS_W-1:0]    read_pos,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    cursor_pos,
    output logic [7:0]                    line_length,
    output logic                          insert_on,
    output logic                          finished,
    output logic [kle_pkg::CHAR_W-1:0]    read_char,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kle_pkg::ADDR_W-1:0]    paddr,
    input  logic [kle_pkg::DATA_W-1:0]    pwdata,
    output logic [kle_pkg::DATA_W-1:0]    prdata
);
    import kle_pkg::*;

    // editor state
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic              ins_reg, ins_next;
    logic [MAXL_W-1:0] max_len_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              up_reg, up_next;
    logic              fin_reg, fin_next;

    // latched request
    logic              func_reg;
    logic [CODE_W-1:0] code_reg;
    logic [RPOS_W-1:0] rpos_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        cursor_out_reg;
    logic [7:0]        length_out_reg;
    logic              insert_out_reg;
    logic              fin_out_reg;
    logic [CHAR_W-1:0] char_out_reg;

    // ram ports
    logic              ram_we;
    logic [PTR_W-1:0]  ram_wa;
    logic [CHAR_W-1:0] ram_wd;
    logic              ram_re;
    logic [PTR_W-1:0]  ram_ra;
    logic [CHAR_W-1:0] ram_rd;

    // widened views for compares
    logic [WIDE_W-1:0] lim_w;
    logic [WIDE_W-1:0] max_w;
    logic [WIDE_W-1:0] len_w;
    logic [WIDE_W-1:0] cur_w;
    logic [WIDE_W-1:0] idx_w;
    logic [CNT_W-1:0]  shift_src;
    logic [CNT_W-1:0]  len_base;
    logic [CNT_W-1:0]  cur_inc;
    logic [CODE_W-1:0] code_in;
    logic              cfg_wr;
    logic              cur_ok;

    assign max_w = WIDE_W'(max_len_reg);
    assign lim_w = (max_w > WIDE_W'(LINE_CAP)) ? WIDE_W'(LINE_CAP) : max_w;
    assign len_w = WIDE_W'(len_reg);
    assign cur_w = WIDE_W'(cur_reg);
    assign idx_w = WIDE_W'(idx_reg);
    assign cur_ok  = (cur_w < lim_w);
    assign cur_inc = cur_reg + CNT_W'(1);

    // key code: zero low byte selects the extended scan code
    assign code_in = (key_word[7:0] == 8'd0) ? {1'b1, key_word[15:8]} : {1'b0, key_word[7:0]};

    // status toward the controller
    always_comb
    begin
        sts.is_read    = func_reg;
        sts.is_print   = (code_reg >= PRINT_LO) && (code_reg < PRINT_HI);
        sts.need_open  = sts.is_print && ins_reg && (len_w < lim_w);
        sts.need_close = ((code_reg == KEY_DEL) && (cur_w < len_w)) ||
                         ((code_reg == KEY_BKSP) && (cur_reg != '0));
        sts.more       = up_reg ? (idx_w > cur_w) : ((idx_w + WIDE_W'(1)) < len_w);
        sts.shift_up   = up_reg;
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    // tail shift source: one below when opening, one above when closing
    assign shift_src = up_reg ? (idx_reg - CNT_W'(1)) : (idx_reg + CNT_W'(1));
    assign len_base  = sts.need_open ? (len_reg + CNT_W'(1)) : len_reg;

    // ram port muxing
    always_comb
    begin
        ram_re = cmd.rd;
        ram_ra = func_reg ? PTR_W'(rpos_reg) : shift_src[PTR_W-1:0];
        ram_we = 1'b0;
        ram_wa = idx_reg[PTR_W-1:0];
        ram_wd = ram_rd;
        if (cmd.wr)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.put && cur_ok)
        begin
            ram_we = 1'b1;
            ram_wa = cur_reg[PTR_W-1:0];
            ram_wd = code_reg[CHAR_W-1:0];
        end
    end

    // editor state updates
    always_comb
    begin
        len_next = len_reg;
        cur_next = cur_reg;
        ins_next = ins_reg;
        idx_next = idx_reg;
        up_next  = up_reg;
        fin_next = fin_reg;
        if (cmd.load)
        begin
            fin_next = 1'b0;
        end
        else if (cmd.shift_init)
        begin
            up_next = sts.is_print;
            if (sts.is_print)
            begin
                idx_next = len_reg;
            end
            else if (code_reg == KEY_DEL)
            begin
                idx_next = cur_reg;
            end
            else
            begin
                idx_next = cur_reg - CNT_W'(1);
            end
        end
        else if (cmd.wr)
        begin
            idx_next = shift_src;
        end
        else if (cmd.put)
        begin
            len_next = len_base;
            if (cur_ok)
            begin
                cur_next = cur_inc;
                if (cur_inc > len_base)
                begin
                    len_next = cur_inc;
                end
            end
        end
        else if (cmd.close)
        begin
            len_next = len_reg - CNT_W'(1);
            if (code_reg == KEY_BKSP)
            begin
                cur_next = cur_reg - CNT_W'(1);
            end
        end
        else if (cmd.apply)
        begin
            case (code_reg)
                KEY_LEFT:
                begin
                    if (cur_reg != '0)
                    begin
                        cur_next = cur_reg - CNT_W'(1);
                    end
                end
                KEY_RIGHT:
                begin
                    if (cur_w < len_w)
                    begin
                        cur_next = cur_inc;
                    end
                end
                KEY_INS:      ins_next = !ins_reg;
                KEY_END:      cur_next = len_reg;
                KEY_HOME:     cur_next = '0;
                KEY_CTRL_END: len_next = cur_reg;
                KEY_ENTER:    fin_next = 1'b1;
                KEY_ESC:      fin_next = 1'b1;
                default:      fin_next = fin_reg;
            endcase
        end
        else if (cmd.out_load && fin_reg)
        begin
            // session ends: cursor returns home after reporting
            cur_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            cur_reg       <= '0;
            ins_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            up_reg        <= 1'b0;
            idx_reg       <= '0;
            max_len_reg   <= MAX_LEN_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            ins_reg       <= ins_next;
            fin_reg       <= fin_next;
            up_reg        <= up_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                max_len_reg <= pwdata[MAXL_W-1:0];
            end
        end
    end

    // configuration write and read
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_MAX_LEN);
    assign prdata = (paddr[2] == CFG_IDX_MAX_LEN) ? DATA_W'(max_len_reg) : '0;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            code_reg <= code_in;
            rpos_reg <= read_pos;
        end
    end

    // result register
    assign out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            cursor_out_reg <= 8'(cur_reg);
            length_out_reg <= 8'(len_reg);
            insert_out_reg <= ins_reg;
            fin_out_reg    <= fin_reg;
            if (func_reg && (WIDE_W'(rpos_reg) < len_w))
            begin
                char_out_reg <= ram_rd;
            end
            else
            begin
                char_out_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign cursor_pos  = cursor_out_reg;
    assign line_length = length_out_reg;
    assign insert_on   = insert_out_reg;
    assign finished    = fin_out_reg;
    assign read_char   = char_out_reg;

    // line buffer
    kle_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_CAP)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

`ifndef ASSERT_OFF
    a_cur_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= len_reg)
        else $error("cursor beyond line length");

    a_len_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_w <= WIDE_W'(LINE_CAP))
        else $error("line length beyond capacity");

    a_shift_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> (idx_w <= len_w))
        else $error("tail shift writes past the line");
`endif

endmodule

>>> hdl/keystroke_line_editor.sv
// keystroke line editor: top level joining the controller and the datapath
//
// Input channel (in_valid/in_stall, func, key_word, read_pos): one request per
// keystroke (func 0) or per character read (func 1). Output channel
// (out_valid/out_stall): exactly one result per request, in order, with the
// cursor, length, insert flag, finished flag and the character read.
// The APB port holds max_len at byte address 0; the user must see that it is
// written only while idle, as the block itself does not enforce this. One
// request is worked on at a time; in_stall is high from acceptance until its
// result is loaded into the output register. An insert, delete or backspace
// moves the tail characters through the single line ram, one read and one
// write per character.
// A new request is taken as soon as the result is in the output register.
// When the receiver stalls, the result holds in the output register and the
// next request waits in its final step until that register frees.
// Reset clears length, cursor and insert flag, sets max_len to 80, and drops
// out_valid; line contents are undefined until written.
module keystroke_line_editor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [kle_pkg::KEY_W-1:0]     key_word,
    input  logic [kle_pkg::RPOS_W-1:0]    read_pos,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    cursor_pos,
    output logic [7:0]                    line_length,
    output logic                          insert_on,
    output logic                          finished,
    output logic [kle_pkg::CHAR_W-1:0]    read_char,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kle_pkg::ADDR_W-1:0]    paddr,
    input  logic [kle_pkg::DATA_W-1:0]    pwdata,
    output logic [kle_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import kle_pkg::*;

    kle_cmd_t cmd;
    kle_sts_t sts;

    // register port has no wait states
    assign pready = 1'b1;

    // sequencer
    kle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // line storage and editing datapath
    kle_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .key_word    (key_word),
        .read_pos    (read_pos),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cursor_pos  (cursor_pos),
        .line_length (line_length),
        .insert_on   (insert_on),
        .finished    (finished),
        .read_char   (read_char),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata)
    );

endmodule

>>> sim/tb.sv
// testbench for the keystroke line editor: directed table, random edit sessions, self-checking
module tb;
    import kle_pkg::*;

    // request kinds and rows of the directed table
    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [1:0] {ROW_KEY, ROW_READ, ROW_LIMIT} row_kind_t;

    typedef struct packed {
        logic [7:0] cursor;
        logic [7:0] length;
        logic       insert;
        logic       finished;
        logic [7:0] rch;
    } edit_result_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [15:0]  arg;
        logic         typed;
        edit_result_t res;
    } directed_row_t;

    // arrow keys with no effect on the line
    localparam logic [CODE_W-1:0] KEY_UP   = 9'd328;
    localparam logic [CODE_W-1:0] KEY_DOWN = 9'd336;

    // raw key words: extended keys carry the code in the scan byte
    localparam logic [15:0] W_LEFT     = {KEY_LEFT[7:0], 8'h00};
    localparam logic [15:0] W_RIGHT    = {KEY_RIGHT[7:0], 8'h00};
    localparam logic [15:0] W_HOME     = {KEY_HOME[7:0], 8'h00};
    localparam logic [15:0] W_END      = {KEY_END[7:0], 8'h00};
    localparam logic [15:0] W_DEL      = {KEY_DEL[7:0], 8'h00};
    localparam logic [15:0] W_INS      = {KEY_INS[7:0], 8'h00};
    localparam logic [15:0] W_CTRL_END = {KEY_CTRL_END[7:0], 8'h00};
    localparam logic [15:0] W_UP       = {KEY_UP[7:0], 8'h00};
    localparam logic [15:0] W_DOWN     = {KEY_DOWN[7:0], 8'h00};
    localparam logic [15:0] W_BKSP     = {8'h0E, KEY_BKSP[7:0]};
    localparam logic [15:0] W_ENTER    = {8'h1C, KEY_ENTER[7:0]};
    localparam logic [15:0] W_ESC      = {8'h01, KEY_ESC[7:0]};

    localparam logic [15:0] NAV_WORDS [16] = '{W_LEFT, W_LEFT, W_LEFT, W_RIGHT, W_RIGHT,
        W_HOME, W_END, W_DEL, W_DEL, W_BKSP, W_BKSP, W_BKSP, W_INS, W_CTRL_END, W_UP, W_DOWN};

    localparam logic [ADDR_W-1:0] MAX_LEN_ADDR = ADDR_W'(4 * int'(CFG_IDX_MAX_LEN));

    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_TAIL      = 2 * LINE_CAP + 8;
    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 93;
    localparam logic [7:0] PHASE_LIMITS [6] = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd7, 8'd80};

    localparam edit_result_t EMPTY_LINE = '0;
    localparam edit_result_t FIRST_CHAR = '{cursor: 8'd1, length: 8'd1, default: '0};

    // directed table: typed results only right after reset
    directed_row_t directed_rows [$] = '{
        '{ROW_READ,  16'd0,      1'b1, EMPTY_LINE},
        '{ROW_READ,  16'd127,    1'b1, EMPTY_LINE},
        '{ROW_KEY,   16'h0000,   1'b1, EMPTY_LINE},
        '{ROW_KEY,   16'hFFFF,   1'b1, EMPTY_LINE},
        '{ROW_KEY,   16'h1E41,   1'b1, FIRST_CHAR},
        '{ROW_KEY,   16'h0B7E,   1'b0, EMPTY_LINE},
        '{ROW_KEY,   16'h3920,   1'b0, EMPTY_LINE},
        '{ROW_KEY,   16'h0E7F,   1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_INS,      1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_HOME,     1'b0, EMPTY_LINE},
        '{ROW_KEY,   16'h1F73,   1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_LEFT,     1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_DEL,      1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_END,      1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_BKSP,     1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_UP,       1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_HOME,     1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_RIGHT,    1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_CTRL_END, 1'b0, EMPTY_LINE},
        '{ROW_READ,  16'd0,      1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_ENTER,    1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_ESC,      1'b0, EMPTY_LINE},
        '{ROW_LIMIT, 16'd2,      1'b0, EMPTY_LINE},
        '{ROW_KEY,   16'h2D78,   1'b0, EMPTY_LINE},
        '{ROW_KEY,   16'h1579,   1'b0, EMPTY_LINE},
        '{ROW_KEY,   16'h2C7A,   1'b0, EMPTY_LINE},
        '{ROW_LIMIT, 16'd1,      1'b0, EMPTY_LINE},
        '{ROW_KEY,   16'h1071,   1'b0, EMPTY_LINE},
        '{ROW_LIMIT, 16'd0,      1'b0, EMPTY_LINE},
        '{ROW_KEY,   W_HOME,     1'b0, EMPTY_LINE},
        '{ROW_KEY,   16'h1177,   1'b0, EMPTY_LINE}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 func;
    logic [KEY_W-1:0]     key_word;
    logic [RPOS_W-1:0]    read_pos;
    logic                 out_valid;
    logic                 out_stall;
    logic [7:0]           cursor_pos;
    logic [7:0]           line_length;
    logic                 insert_on;
    logic                 finished;
    logic [CHAR_W-1:0]    read_char;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // shadow copy of the editor state
    logic [7:0]   shadow_line [LINE_CAP];
    int           shadow_len;
    int           shadow_cursor;
    logic         shadow_insert;
    logic [7:0]   shadow_max_len;

    edit_result_t expected_results [$];
    edit_result_t want;
    logic         row_typed;
    edit_result_t row_expect;
    logic         quiet;
    int           mismatch_count;
    int           idle_cycles;

    keystroke_line_editor uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key_word    (key_word),
        .read_pos    (read_pos),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cursor_pos  (cursor_pos),
        .line_length (line_length),
        .insert_on   (insert_on),
        .finished    (finished),
        .read_char   (read_char),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
    endtask

    // remove one character and close the gap
    function automatic void drop_char(input int pos);
        for (int i = pos; i + 1 < shadow_len; i++)
            shadow_line[i] = shadow_line[i + 1];
        shadow_len--;
    endfunction

    // apply one request to the shadow line and return what the editor reports
    function automatic edit_result_t predict_edit(input logic f, input logic [15:0] kw,
                                                  input logic [6:0] rp);
        edit_result_t r;
        logic [CODE_W-1:0] code;
        int cap;
        r = '0;
        cap = (shadow_max_len > LINE_CAP) ? LINE_CAP : int'(shadow_max_len);
        if (f == FUNC_READ)
        begin
            if (rp < shadow_len)
                r.rch = shadow_line[rp];
        end
        else
        begin
            code = (kw[7:0] == 8'h00) ? {1'b1, kw[15:8]} : {1'b0, kw[7:0]};
            if (code >= PRINT_LO && code < PRINT_HI)
            begin
                // insert opens a slot only while the line has room
                if (shadow_insert && shadow_len < cap)
                begin
                    for (int i = shadow_len; i > shadow_cursor; i--)
                        shadow_line[i] = shadow_line[i - 1];
                    shadow_len++;
                end
                if (shadow_cursor < cap)
                begin
                    shadow_line[shadow_cursor] = code[7:0];
                    shadow_cursor++;
                    if (shadow_cursor > shadow_len)
                        shadow_len = shadow_cursor;
                end
            end
            else
            begin
                case (code)
                    KEY_DEL:
                        if (shadow_cursor < shadow_len)
                            drop_char(shadow_cursor);
                    KEY_BKSP:
                        if (shadow_cursor > 0)
                        begin
                            drop_char(shadow_cursor - 1);
                            shadow_cursor--;
                        end
                    KEY_LEFT:
                        if (shadow_cursor > 0)
                            shadow_cursor--;
                    KEY_RIGHT:
                        if (shadow_cursor < shadow_len)
                            shadow_cursor++;
                    KEY_INS:      shadow_insert = ~shadow_insert;
                    KEY_END:      shadow_cursor = shadow_len;
                    KEY_HOME:     shadow_cursor = 0;
                    KEY_CTRL_END: shadow_len = shadow_cursor;
                    KEY_ENTER, KEY_ESC: r.finished = 1'b1;
                    default: ;
                endcase
            end
        end
        r.cursor = 8'(shadow_cursor);
        if (r.finished)
            shadow_cursor = 0;
        r.length = 8'(shadow_len);
        r.insert = shadow_insert;
        return r;
    endfunction

    // printable keys at the given percentage, then editing keys, session ends and raw noise
    function automatic logic [15:0] pick_key_word(input int pct_print);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < pct_print)
            return {8'($urandom_range(0, 255)), 8'($urandom_range(32, 126))};
        else if (roll < 94)
            return NAV_WORDS[$urandom_range(0, 15)];
        else if (roll < 97)
            return ($urandom_range(0, 1) == 0) ? W_ENTER : W_ESC;
        return 16'($urandom_range(0, 65535));
    endfunction

    // present one request and hold it until the editor takes it
    task automatic send_request(input logic f, input logic [15:0] kw, input logic [6:0] rp,
                                input logic typed, input edit_result_t typed_res);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 21)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        row_typed  = typed;
        row_expect = typed_res;
        in_valid <= 1'b1;
        func     <= f;
        key_word <= kw;
        read_pos <= rp;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // write max_len once the editor is idle, then read it back
    task automatic program_max_len(input logic [7:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_LEN_ADDR;
        pwdata  <= {24'h0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_max_len = val;
        @(negedge clk);
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("max_len readback", prdata, {24'h0, val});
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // receiver stalls at random outside the quiet stretch
    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < 21);

    // predict on every accepted request, compare every accepted result
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            want = predict_edit(func, key_word, read_pos);
            if (row_typed)
                want = row_expect;
            expected_results.push_back(want);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no request waiting");
            else
            begin
                want = expected_results.pop_front();
                check_field("cursor_pos", 32'(cursor_pos), 32'(want.cursor));
                check_field("line_length", 32'(line_length), 32'(want.length));
                check_field("insert_on", 32'(insert_on), 32'(want.insert));
                check_field("finished", 32'(finished), 32'(want.finished));
                check_field("read_char", 32'(read_char), 32'(want.rch));
            end
        end
    end

    // watchdog on cycles with no traffic on either channel
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // main sequence
    initial
    begin
        logic [7:0] lim;
        int pct_print;
        int reach;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = FUNC_KEY;
        key_word       = '0;
        read_pos       = '0;
        out_stall      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        row_typed      = 1'b0;
        row_expect     = '0;
        quiet          = 1'b0;
        mismatch_count = 0;
        shadow_len     = 0;
        shadow_cursor  = 0;
        shadow_insert  = 1'b0;
        shadow_max_len = MAX_LEN_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_LIMIT: program_max_len(directed_rows[i].arg[7:0]);
                ROW_READ:  send_request(FUNC_READ, 16'h0000, directed_rows[i].arg[6:0],
                                        directed_rows[i].typed, directed_rows[i].res);
                default:   send_request(FUNC_KEY, directed_rows[i].arg, 7'd0,
                                        directed_rows[i].typed, directed_rows[i].res);
            endcase
        end

        // random sessions, one limit per phase, last phase at a random limit
        for (int p = 0; p < N_PHASES; p++)
        begin
            lim = (p == N_PHASES - 1) ? 8'($urandom_range(1, 128)) : PHASE_LIMITS[p];
            program_max_len(lim);
            quiet = (p == 3);
            pct_print = (lim >= 100) ? 70 : 45;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    reach = (shadow_len > 127) ? 127 : shadow_len;
                    if ($urandom_range(0, 1) == 0)
                        send_request(FUNC_READ, 16'($urandom_range(0, 65535)),
                                     7'($urandom_range(0, 127)), 1'b0, EMPTY_LINE);
                    else
                        send_request(FUNC_READ, 16'($urandom_range(0, 65535)),
                                     7'($urandom_range(0, reach)), 1'b0, EMPTY_LINE);
                end
                else
                    send_request(FUNC_KEY, pick_key_word(pct_print),
                                 7'($urandom_range(0, 127)), 1'b0, EMPTY_LINE);
            end
            quiet = 1'b0;
        end

        // drain and finish
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
